### hdl/mljs_pkg.sv
// Shared constants, datapath command codes and status types of the Metropolis step core.
package mljs_pkg;

  localparam int GRID_SIDE = 100;
  localparam int IDX_W     = $clog2(GRID_SIDE);
  localparam int COEF_W    = IDX_W + 2;
  localparam int GX_W      = COEF_W + 25;
  localparam int DIFF_W    = (IDX_W + 28 > 35) ? IDX_W + 28 : 35;
  localparam int ACC_W     = 2 * IDX_W + 33;

  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SPACING   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_MEAN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THERMAL_ENERGY = 2'd2;

  localparam logic [CFG_W-1:0] RST_GRID_SPACING   = 24'd131072;
  localparam logic [CFG_W-1:0] RST_SIGMA_MEAN     = 24'd36045;
  localparam logic [CFG_W-1:0] RST_THERMAL_ENERGY = 24'd6554;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CUT2,
    OP_GX,
    OP_ROW,
    OP_NEXTI,
    OP_GY,
    OP_COL,
    OP_NEXTJ,
    OP_SQ0,
    OP_SQ1,
    OP_SQ2,
    OP_SQ3,
    OP_ESEL_OLD,
    OP_ESEL_NEW,
    OP_DIVE,
    OP_S2,
    OP_S3,
    OP_C,
    OP_C6,
    OP_ACC,
    OP_DU,
    OP_DIVX,
    OP_TINIT,
    OP_TMUL,
    OP_DIVT,
    OP_TACC,
    OP_PINIT,
    OP_PSQ,
    OP_FIN_TAKE,
    OP_FIN_KEEP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   idle;
  } ctl_cmd_t;

  typedef struct packed {
    logic row_out;
    logic col_out;
    logic far;
    logic sat;
    logic div_busy;
    logic last_i;
    logic last_j;
    logic sel_new;
    logic du_neg;
    logic du_big;
    logic xq_zero;
    logic last_n;
    logic last_sq;
    logic p_gt;
    logic out_free;
  } dp_status_t;

endpackage

### hdl/metropolis_lennard_jones_step_core.sv
// Top level of the Metropolis Lennard-Jones step core: sequencer plus datapath.
// Each item proposes a displacement of the single particle; the core scans the
// GRID_SIDE x GRID_SIDE grid of centres one point at a time, sums pair energies at
// the old and new positions for the points within 10.5 sigma of the old position,
// and runs the Metropolis test against the uniform draw. One item is in work at a
// time. The scan checks every row and the columns of rows that reach the cutoff;
// at each point inside the cutoff the 31-step serial divider computing sigma^2/r^2
// for the old and new distance dominates. The acceptance test is mostly twelve
// 32-step divisions of the exponential series on the same divider. A finished
// result waits in the output register while the next item is taken; configuration
// writes are accepted in every cycle.
module metropolis_lennard_jones_step_core
  import mljs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   in_step_x,
  input  logic signed [31:0]   in_step_y,
  input  logic [15:0]          in_uniform_draw,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_pos_x,
  output logic signed [31:0]   out_pos_y,
  output logic                 out_move_taken,
  output logic signed [31:0]   out_energy_change,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  ctl_cmd_t   cmd;
  dp_status_t status;
  logic       in_accept;

  assign in_stall  = ~cmd.idle;
  assign in_accept = in_valid & cmd.idle;
  assign cfg_ready = 1'b1;

  mljs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd)
  );

  mljs_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_accept         (in_accept),
    .in_step_x         (in_step_x),
    .in_step_y         (in_step_y),
    .in_uniform_draw   (in_uniform_draw),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_move_taken    (out_move_taken),
    .out_energy_change (out_energy_change),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .cfg_write         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

endmodule

### hdl/mljs_ctrl.sv
// Sequencer that steps the datapath through the grid scan, energy and acceptance test.
module mljs_ctrl
  import mljs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  dp_status_t status,
  output ctl_cmd_t   cmd
);

  typedef enum logic [5:0] {
    S_IDLE, S_CUT2, S_GX, S_ROW, S_ROWCHK, S_GY, S_COL, S_COLCHK,
    S_SQ0, S_SQ1, S_FARCHK, S_SQ2, S_SQ3, S_ESELO, S_ESELN, S_SATCHK,
    S_DIVE, S_DIVEW, S_S2, S_S3, S_C, S_C6, S_ACC, S_NEXTJ, S_NEXTI,
    S_DU, S_DUCHK, S_DIVX, S_DIVXW, S_XCHK, S_TINIT, S_TMUL, S_DIVT,
    S_DIVTW, S_TACC, S_PINIT, S_PSQ, S_DECIDE, S_FINT, S_FINR
  } state_t;

  state_t   state_r, state_nxt;
  ctl_cmd_t cmd_r;

  function automatic dp_op_t op_of(input state_t s);
    dp_op_t o;
    case (s)
      S_CUT2:  o = OP_CUT2;
      S_GX:    o = OP_GX;
      S_ROW:   o = OP_ROW;
      S_NEXTI: o = OP_NEXTI;
      S_GY:    o = OP_GY;
      S_COL:   o = OP_COL;
      S_NEXTJ: o = OP_NEXTJ;
      S_SQ0:   o = OP_SQ0;
      S_SQ1:   o = OP_SQ1;
      S_SQ2:   o = OP_SQ2;
      S_SQ3:   o = OP_SQ3;
      S_ESELO: o = OP_ESEL_OLD;
      S_ESELN: o = OP_ESEL_NEW;
      S_DIVE:  o = OP_DIVE;
      S_S2:    o = OP_S2;
      S_S3:    o = OP_S3;
      S_C:     o = OP_C;
      S_C6:    o = OP_C6;
      S_ACC:   o = OP_ACC;
      S_DU:    o = OP_DU;
      S_DIVX:  o = OP_DIVX;
      S_TINIT: o = OP_TINIT;
      S_TMUL:  o = OP_TMUL;
      S_DIVT:  o = OP_DIVT;
      S_TACC:  o = OP_TACC;
      S_PINIT: o = OP_PINIT;
      S_PSQ:   o = OP_PSQ;
      S_FINT:  o = OP_FIN_TAKE;
      S_FINR:  o = OP_FIN_KEEP;
      default: o = OP_NONE;
    endcase
    return o;
  endfunction

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_CUT2;
      S_CUT2:   state_nxt = S_GX;
      S_GX:     state_nxt = S_ROW;
      S_ROW:    state_nxt = S_ROWCHK;
      S_ROWCHK: state_nxt = status.row_out ? S_NEXTI : S_GY;
      S_GY:     state_nxt = S_COL;
      S_COL:    state_nxt = S_COLCHK;
      S_COLCHK: state_nxt = status.col_out ? S_NEXTJ : S_SQ0;
      S_SQ0:    state_nxt = S_SQ1;
      S_SQ1:    state_nxt = S_FARCHK;
      S_FARCHK: state_nxt = status.far ? S_NEXTJ : S_SQ2;
      S_SQ2:    state_nxt = S_SQ3;
      S_SQ3:    state_nxt = S_ESELO;
      S_ESELO:  state_nxt = S_SATCHK;
      S_ESELN:  state_nxt = S_SATCHK;
      S_SATCHK: state_nxt = status.sat ? S_ACC : S_DIVE;
      S_DIVE:   state_nxt = S_DIVEW;
      S_DIVEW:  if (!status.div_busy) state_nxt = S_S2;
      S_S2:     state_nxt = S_S3;
      S_S3:     state_nxt = S_C;
      S_C:      state_nxt = S_C6;
      S_C6:     state_nxt = S_ACC;
      S_ACC:    state_nxt = status.sel_new ? S_NEXTJ : S_ESELN;
      S_NEXTJ:  state_nxt = status.last_j ? S_NEXTI : S_GY;
      S_NEXTI:  state_nxt = status.last_i ? S_DU : S_GX;
      S_DU:     state_nxt = S_DUCHK;
      S_DUCHK: begin
        if (status.du_neg) state_nxt = S_FINT;
        else if (status.du_big) state_nxt = S_FINR;
        else state_nxt = S_DIVX;
      end
      S_DIVX:   state_nxt = S_DIVXW;
      S_DIVXW:  if (!status.div_busy) state_nxt = S_XCHK;
      S_XCHK:   state_nxt = status.xq_zero ? S_FINT : S_TINIT;
      S_TINIT:  state_nxt = S_TMUL;
      S_TMUL:   state_nxt = S_DIVT;
      S_DIVT:   state_nxt = S_DIVTW;
      S_DIVTW:  if (!status.div_busy) state_nxt = S_TACC;
      S_TACC:   state_nxt = status.last_n ? S_PINIT : S_TMUL;
      S_PINIT:  state_nxt = S_PSQ;
      S_PSQ:    state_nxt = status.last_sq ? S_DECIDE : S_PSQ;
      S_DECIDE: state_nxt = status.p_gt ? S_FINT : S_FINR;
      S_FINT:   if (status.out_free) state_nxt = S_IDLE;
      S_FINR:   if (status.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cmd_r.op   <= OP_NONE;
      cmd_r.idle <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      cmd_r.op   <= op_of(state_nxt);
      cmd_r.idle <= (state_nxt == S_IDLE);
    end
  end

  assign cmd = cmd_r;

endmodule

### hdl/mljs_datapath.sv
// Datapath: configuration, particle state, distance and energy arithmetic, shared divider.
module mljs_datapath
  import mljs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctl_cmd_t             cmd,
  output dp_status_t           status,
  input  logic                 in_accept,
  input  logic signed [31:0]   in_step_x,
  input  logic signed [31:0]   in_step_y,
  input  logic [15:0]          in_uniform_draw,
  output logic signed [31:0]   out_pos_x,
  output logic signed [31:0]   out_pos_y,
  output logic                 out_move_taken,
  output logic signed [31:0]   out_energy_change,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam logic [5:0] DIVE_STEPS = 6'd31;
  localparam logic [5:0] DIVX_STEPS = 6'd20;
  localparam logic [5:0] DIVT_STEPS = 6'd32;
  localparam logic [3:0] TAYLOR_TERMS = 4'd12;
  localparam logic signed [31:0] E_MAX = 32'sh7FFF_FFFF;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
    logic [DIFF_W-1:0] r;
    r = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    return r;
  endfunction

  function automatic logic [30:0] clamp31(input logic [DIFF_W-1:0] v);
    logic [30:0] r;
    r = (|v[DIFF_W-1:31]) ? 31'h7FFF_FFFF : v[30:0];
    return r;
  endfunction

  // Configuration and particle state.
  logic [CFG_W-1:0]   spacing_r, sigma_r, kt_r;
  logic signed [31:0] px_r, py_r, nx_r, ny_r;
  logic [15:0]        draw_r;

  logic [28:0]        cut_r;
  logic [57:0]        cut2_r;
  logic [49:0]        sig2_r;
  logic [IDX_W-1:0]   i_r, j_r;
  logic signed [GX_W-1:0] gx_r, gy_r;
  logic [DIFF_W-1:0]  aox_r, aoy_r;
  logic [30:0]        anx_r, any_r;
  logic [61:0]        prod_r;
  logic [58:0]        r2o_r;
  logic [62:0]        r2n_r, r2_r;
  logic               sel_new_r;

  logic [63:0]        dv_rem_r, dv_den_r;
  logic [31:0]        dv_num_r, dv_q_r;
  logic [5:0]         dv_cnt_r;
  logic               dv_busy_r;

  logic [33:0]        s2_r;
  logic [35:0]        s3_r;
  logic [24:0]        c_r;
  logic [33:0]        c6_r;
  logic signed [ACC_W-1:0] uo_r, un_r;
  logic signed [31:0] du_r;

  logic [32:0]        term_r;
  logic [31:0]        t_r, tp_r, p_r;
  logic signed [35:0] sum_r;
  logic [3:0]         n_r;
  logic [1:0]         sq_cnt_r;

  logic signed [31:0] opx_r, opy_r, oe_r;
  logic               otake_r, ovalid_r;

  // Combinational helpers.
  logic signed [32:0] sx_sum, sy_sum;
  assign sx_sum = {px_r[31], px_r} + {in_step_x[31], in_step_x};
  assign sy_sum = {py_r[31], py_r} + {in_step_y[31], in_step_y};

  logic [28:0] cut_val;
  assign cut_val = {1'b0, sigma_r, 4'b0} + {3'b0, sigma_r, 2'b0} + {5'b0, sigma_r};

  logic [47:0] sig_sq;
  assign sig_sq = sigma_r * sigma_r;

  logic [57:0] cut_sq;
  assign cut_sq = cut_r * cut_r;

  logic signed [COEF_W-1:0] coef_i, coef_j;
  logic signed [CFG_W:0]    sp_s;
  logic signed [GX_W-1:0]   gx_prod, gy_prod;
  assign coef_i  = $signed({1'b0, i_r, 1'b0}) - $signed(COEF_W'(GRID_SIDE - 1));
  assign coef_j  = $signed({1'b0, j_r, 1'b0}) - $signed(COEF_W'(GRID_SIDE - 1));
  assign sp_s    = $signed({1'b0, spacing_r});
  assign gx_prod = coef_i * sp_s;
  assign gy_prod = coef_j * sp_s;

  // Coordinates are in half-LSB units so grid points land exactly.
  logic signed [DIFF_W-1:0] pox2, poy2, pnx2, pny2, gx_ext, gy_ext;
  assign pox2   = {{(DIFF_W-33){px_r[31]}}, px_r, 1'b0};
  assign poy2   = {{(DIFF_W-33){py_r[31]}}, py_r, 1'b0};
  assign pnx2   = {{(DIFF_W-33){nx_r[31]}}, nx_r, 1'b0};
  assign pny2   = {{(DIFF_W-33){ny_r[31]}}, ny_r, 1'b0};
  assign gx_ext = {{(DIFF_W-GX_W){gx_r[GX_W-1]}}, gx_r};
  assign gy_ext = {{(DIFF_W-GX_W){gy_r[GX_W-1]}}, gy_r};

  logic [57:0] aox_sq, aoy_sq;
  logic [61:0] anx_sq, any_sq;
  assign aox_sq = aox_r[28:0] * aox_r[28:0];
  assign aoy_sq = aoy_r[28:0] * aoy_r[28:0];
  assign anx_sq = anx_r * anx_r;
  assign any_sq = any_r * any_r;

  logic [65:0] r2_x6;
  assign r2_x6 = {1'b0, r2_r, 2'b0} + {2'b0, r2_r, 1'b0};

  logic [30:0] q31;
  logic [61:0] qq;
  logic [64:0] s2q;
  logic [36:0] c_sum;
  logic [49:0] cc;
  assign q31   = dv_q_r[30:0];
  assign qq    = q31 * q31;
  assign s2q   = s2_r * q31;
  assign c_sum = {1'b0, s3_r} + 37'd2048;
  assign cc    = c_r * c_r;

  logic signed [35:0] e_raw;
  logic signed [31:0] e_val;
  assign e_raw = $signed({2'b0, c6_r}) - $signed({11'b0, c_r});
  always_comb begin
    if (r2_x6 <= {16'b0, sig2_r}) e_val = E_MAX;
    else if (e_raw > $signed({4'b0, E_MAX})) e_val = E_MAX;
    else e_val = e_raw[31:0];
  end

  logic signed [ACC_W:0] du_wide;
  logic signed [31:0]    du_sat;
  assign du_wide = {un_r[ACC_W-1], un_r} - {uo_r[ACC_W-1], uo_r};
  always_comb begin
    if (du_wide > $signed((ACC_W+1)'(E_MAX))) du_sat = 32'sh7FFF_FFFF;
    else if (du_wide < -$signed((ACC_W+1)'(32'h8000_0000))) du_sat = 32'sh8000_0000;
    else du_sat = du_wide[31:0];
  end

  logic [CFG_W-1:0] kt_eff;
  logic [27:0]      kt12;
  assign kt_eff = (kt_r == '0) ? CFG_W'(1) : kt_r;
  assign kt12   = {1'b0, kt_eff, 3'b0} + {2'b0, kt_eff, 2'b0};

  logic [64:0] tt;
  logic [63:0] pp;
  assign tt = term_r * t_r;
  assign pp = p_r * p_r + 64'h8000_0000;

  // One restoring division step per cycle.
  logic [64:0] dv_sh;
  logic        dv_ge;
  assign dv_sh = {dv_rem_r, dv_num_r[31]};
  assign dv_ge = dv_sh >= {1'b0, dv_den_r};

  logic out_free;
  assign out_free = !ovalid_r || !out_stall;

  // A new result is loaded into the output register in this cycle.
  logic fin_load;
  assign fin_load = out_free && (cmd.op == OP_FIN_TAKE || cmd.op == OP_FIN_KEEP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r <= RST_GRID_SPACING;
      sigma_r   <= RST_SIGMA_MEAN;
      kt_r      <= RST_THERMAL_ENERGY;
      px_r      <= '0;
      py_r      <= '0;
      dv_busy_r <= 1'b0;
      ovalid_r  <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_GRID_SPACING:   spacing_r <= cfg_data;
          CFG_SIGMA_MEAN:     sigma_r   <= cfg_data;
          CFG_THERMAL_ENERGY: kt_r      <= cfg_data;
          default: ;
        endcase
      end

      if (ovalid_r && !out_stall && !fin_load) ovalid_r <= 1'b0;

      if (in_accept) begin
        nx_r   <= sat33(sx_sum);
        ny_r   <= sat33(sy_sum);
        draw_r <= in_uniform_draw;
        cut_r  <= cut_val;
        sig2_r <= {sig_sq, 2'b0};
        i_r    <= '0;
        j_r    <= '0;
        uo_r   <= '0;
        un_r   <= '0;
      end

      if (dv_busy_r) begin
        dv_rem_r  <= dv_ge ? 64'(dv_sh - {1'b0, dv_den_r}) : dv_sh[63:0];
        dv_q_r    <= {dv_q_r[30:0], dv_ge};
        dv_num_r  <= {dv_num_r[30:0], 1'b0};
        dv_cnt_r  <= dv_cnt_r - 6'd1;
        dv_busy_r <= (dv_cnt_r != 6'd1);
      end

      case (cmd.op)
        OP_CUT2:  cut2_r <= cut_sq;
        OP_GX: begin
          gx_r <= gx_prod;
          j_r  <= '0;
        end
        OP_ROW: begin
          aox_r <= mag(pox2 - gx_ext);
          anx_r <= clamp31(mag(pnx2 - gx_ext));
        end
        OP_NEXTI: i_r <= i_r + IDX_W'(1);
        OP_GY:    gy_r <= gy_prod;
        OP_COL: begin
          aoy_r <= mag(poy2 - gy_ext);
          any_r <= clamp31(mag(pny2 - gy_ext));
        end
        OP_NEXTJ: j_r <= j_r + IDX_W'(1);
        OP_SQ0:   prod_r <= {4'b0, aox_sq};
        OP_SQ1:   r2o_r <= {1'b0, prod_r[57:0]} + {1'b0, aoy_sq};
        OP_SQ2:   prod_r <= anx_sq;
        OP_SQ3:   r2n_r <= {1'b0, prod_r} + {1'b0, any_sq};
        OP_ESEL_OLD: begin
          r2_r      <= {4'b0, r2o_r};
          sel_new_r <= 1'b0;
        end
        OP_ESEL_NEW: begin
          r2_r      <= r2n_r;
          sel_new_r <= 1'b1;
        end
        OP_DIVE: begin
          // Quotient is sig2 * 2^28 / r2, below 6 * 2^28 once saturation is excluded.
          dv_rem_r  <= {17'b0, sig2_r[49:3]};
          dv_num_r  <= {sig2_r[2:0], 29'b0};
          dv_den_r  <= {1'b0, r2_r};
          dv_q_r    <= '0;
          dv_cnt_r  <= DIVE_STEPS;
          dv_busy_r <= 1'b1;
        end
        OP_S2:  s2_r <= qq[61:28];
        OP_S3:  s3_r <= s2q[63:28];
        OP_C:   c_r  <= c_sum[36:12];
        OP_C6:  c6_r <= cc[49:16];
        OP_ACC: begin
          if (sel_new_r) un_r <= un_r + ACC_W'(e_val);
          else uo_r <= uo_r + ACC_W'(e_val);
        end
        OP_DU: du_r <= du_sat;
        OP_DIVX: begin
          // Only reached when dU < 12 kT, so the quotient fits in 20 bits.
          dv_rem_r  <= {37'b0, du_r[30:4]};
          dv_num_r  <= {du_r[3:0], 28'b0};
          dv_den_r  <= {40'b0, kt_eff};
          dv_q_r    <= '0;
          dv_cnt_r  <= DIVX_STEPS;
          dv_busy_r <= 1'b1;
        end
        OP_TINIT: begin
          term_r <= 33'h1_0000_0000;
          sum_r  <= 36'sh1_0000_0000;
          n_r    <= 4'd1;
          t_r    <= {dv_q_r[19:0], 12'b0};
        end
        OP_TMUL: tp_r <= tt[63:32];
        OP_DIVT: begin
          dv_rem_r  <= '0;
          dv_num_r  <= tp_r;
          dv_den_r  <= {60'b0, n_r};
          dv_q_r    <= '0;
          dv_cnt_r  <= DIVT_STEPS;
          dv_busy_r <= 1'b1;
        end
        OP_TACC: begin
          term_r <= {1'b0, dv_q_r};
          if (n_r[0]) sum_r <= sum_r - $signed({4'b0, dv_q_r});
          else sum_r <= sum_r + $signed({4'b0, dv_q_r});
          n_r <= n_r + 4'd1;
        end
        OP_PINIT: begin
          if (sum_r[35]) p_r <= '0;
          else if (|sum_r[34:32]) p_r <= 32'hFFFF_FFFF;
          else p_r <= sum_r[31:0];
          sq_cnt_r <= '0;
        end
        OP_PSQ: begin
          p_r      <= pp[63:32];
          sq_cnt_r <= sq_cnt_r + 2'd1;
        end
        OP_FIN_TAKE: begin
          if (out_free) begin
            px_r     <= nx_r;
            py_r     <= ny_r;
            opx_r    <= nx_r;
            opy_r    <= ny_r;
            otake_r  <= 1'b1;
            oe_r     <= du_r;
            ovalid_r <= 1'b1;
          end
        end
        OP_FIN_KEEP: begin
          if (out_free) begin
            opx_r    <= px_r;
            opy_r    <= py_r;
            otake_r  <= 1'b0;
            oe_r     <= du_r;
            ovalid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign status.row_out  = aox_r >= {{(DIFF_W-29){1'b0}}, cut_r};
  assign status.col_out  = aoy_r >= {{(DIFF_W-29){1'b0}}, cut_r};
  assign status.far      = r2o_r >= {1'b0, cut2_r};
  assign status.sat      = r2_x6 <= {16'b0, sig2_r};
  assign status.div_busy = dv_busy_r;
  assign status.last_i   = (i_r == IDX_W'(GRID_SIDE - 1));
  assign status.last_j   = (j_r == IDX_W'(GRID_SIDE - 1));
  assign status.sel_new  = sel_new_r;
  assign status.du_neg   = du_r[31];
  assign status.du_big   = {1'b0, du_r[30:0]} >= {4'b0, kt12};
  assign status.xq_zero  = (dv_q_r[19:0] == '0);
  assign status.last_n   = (n_r == TAYLOR_TERMS);
  assign status.last_sq  = (sq_cnt_r == 2'd3);
  assign status.p_gt     = p_r > {draw_r, 16'b0};
  assign status.out_free = out_free;

  assign out_pos_x         = opx_r;
  assign out_pos_y         = opy_r;
  assign out_move_taken    = otake_r;
  assign out_energy_change = oe_r;
  assign out_valid         = ovalid_r;

endmodule

### test/metropolis_lennard_jones_step_core_tb.sv
// Self-checking testbench of the Metropolis Lennard-Jones step core.
module metropolis_lennard_jones_step_core_tb;
  import mljs_pkg::*;

  localparam longint RUN_LIMIT = 20000000;
  localparam int     DRAIN_CYCLES = 100;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               move_taken;
    logic signed [31:0] energy_change;
  } move_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [31:0]   in_step_x = '0;
  logic signed [31:0]   in_step_y = '0;
  logic [15:0]          in_uniform_draw = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [31:0]   out_pos_x;
  logic signed [31:0]   out_pos_y;
  logic                 out_move_taken;
  logic signed [31:0]   out_energy_change;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  move_result_t pending_moves[$];
  int           error_count = 0;
  longint       cycle_count = 0;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  logic         hold_off = 1'b0;

  // Shadow of the block's registers and particle position.
  longint spacing_reg, sigma_reg, kt_reg;
  longint part_x, part_y;

  metropolis_lennard_jones_step_core u_top (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= rst_n && (hold_off || ($urandom_range(99) < stall_pct));
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned abs64(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic longint pair_energy(longint unsigned r2, longint unsigned sig2);
    longint unsigned q, rem, s2, s3, c, c6;
    longint e;
    if (r2 <= sig2 / 6) return 64'sd2147483647;
    q = sig2 / r2;
    rem = sig2 % r2;
    for (int k = 0; k < 28; k++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= r2) begin
        rem = rem - r2;
        q = q | 64'd1;
      end
    end
    s2 = (q * q) >> 28;
    s3 = (s2 * q) >> 28;
    c = (s3 + (64'd1 << 11)) >> 12;
    c6 = (c * c) >> 16;
    e = longint'(c6) - longint'(c);
    return (e > 64'sd2147483647) ? 64'sd2147483647 : e;
  endfunction

  // Exponential by a Taylor series at x/16, then four squarings.
  function automatic logic metropolis_accept(longint du, logic [15:0] draw);
    longint unsigned kt, xq, t, term, p;
    longint sum;
    if (du < 0) return 1'b1;
    kt = (kt_reg == 0) ? 64'd1 : kt_reg;
    xq = (longint'(du) << 16) / kt;
    if (xq >= (64'd12 << 16)) return 1'b0;
    if (xq == 0) return 1'b1;
    t = xq << 12;
    term = 64'd1 << 32;
    sum = 64'sd1 << 32;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * t) >> 32) / n;
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    p = sum;
    if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
    for (int n = 0; n < 4; n++) p = (p * p + (64'd1 << 31)) >> 32;
    return p > (longint'(draw) << 16);
  endfunction

  function automatic move_result_t predict_move(logic signed [31:0] sx, logic signed [31:0] sy,
                                                logic [15:0] draw);
    move_result_t r;
    longint nx, ny, gx, gy, u_old, u_new, du;
    longint unsigned sig2, cut, cut2, aox, anx, aoy, any_d, r2o, r2n;
    logic take;
    nx = clamp32(part_x + longint'(sx));
    ny = clamp32(part_y + longint'(sy));
    sig2 = 4 * sigma_reg * sigma_reg;
    cut = 21 * sigma_reg;
    cut2 = cut * cut;
    u_old = 0;
    u_new = 0;
    for (int i = 0; i < GRID_SIDE; i++) begin
      gx = longint'(2 * i - (GRID_SIDE - 1)) * spacing_reg;
      aox = abs64(2 * part_x - gx);
      anx = abs64(2 * nx - gx);
      if (aox >= cut) continue;
      if (anx > 64'h7FFF_FFFF) anx = 64'h7FFF_FFFF;
      for (int j = 0; j < GRID_SIDE; j++) begin
        gy = longint'(2 * j - (GRID_SIDE - 1)) * spacing_reg;
        aoy = abs64(2 * part_y - gy);
        if (aoy >= cut) continue;
        r2o = aox * aox + aoy * aoy;
        if (r2o >= cut2) continue;
        any_d = abs64(2 * ny - gy);
        if (any_d > 64'h7FFF_FFFF) any_d = 64'h7FFF_FFFF;
        r2n = anx * anx + any_d * any_d;
        u_old = u_old + pair_energy(r2o, sig2);
        u_new = u_new + pair_energy(r2n, sig2);
      end
    end
    du = clamp32(u_new - u_old);
    take = metropolis_accept(du, draw);
    if (take) begin
      part_x = nx;
      part_y = ny;
    end
    r.pos_x = part_x[31:0];
    r.pos_y = part_y[31:0];
    r.move_taken = take;
    r.energy_change = du[31:0];
    return r;
  endfunction

  // Result checker: every accepted output item is matched with the oldest prediction.
  always @(posedge clk) begin
    move_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_moves.size() == 0) begin
        $display("%0t: unexpected result item pos_x %h", $realtime, out_pos_x);
        error_count++;
      end else begin
        exp_r = pending_moves.pop_front();
        if (out_pos_x !== exp_r.pos_x) begin
          $display("%0t: pos_x expected %h actual %h", $realtime, exp_r.pos_x, out_pos_x);
          error_count++;
        end
        if (out_pos_y !== exp_r.pos_y) begin
          $display("%0t: pos_y expected %h actual %h", $realtime, exp_r.pos_y, out_pos_y);
          error_count++;
        end
        if (out_move_taken !== exp_r.move_taken) begin
          $display("%0t: move_taken expected %b actual %b", $realtime, exp_r.move_taken,
                   out_move_taken);
          error_count++;
        end
        if (out_energy_change !== exp_r.energy_change) begin
          $display("%0t: energy_change expected %h actual %h", $realtime,
                   exp_r.energy_change, out_energy_change);
          error_count++;
        end
      end
    end
  end

  task automatic send_move(logic signed [31:0] sx, logic signed [31:0] sy, logic [15:0] draw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_step_x <= sx;
    in_step_y <= sy;
    in_uniform_draw <= draw;
    do @(posedge clk); while (in_stall);
    pending_moves.push_back(predict_move(sx, sy, draw));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_moves.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_GRID_SPACING:   spacing_reg = value & 64'hFF_FFFF;
      CFG_SIGMA_MEAN:     sigma_reg = value & 64'hFF_FFFF;
      CFG_THERMAL_ENERGY: kt_reg = value & 64'hFF_FFFF;
      default: ;
    endcase
  endtask

  task automatic restore_regs();
    write_reg(CFG_GRID_SPACING, RST_GRID_SPACING);
    write_reg(CFG_SIGMA_MEAN, RST_SIGMA_MEAN);
    write_reg(CFG_THERMAL_ENERGY, RST_THERMAL_ENERGY);
  endtask

  task automatic test_reset_moves();
    send_move(0, 0, 16'h0000);
    send_move(32'sd65536, 32'sd65536, 16'hFFFF);     // lands on a grid centre
    send_move(32'sd32768, -32'sd32768, 16'($urandom));
    send_move(-32'sd131072, 0, 16'h8000);
    send_move(0, 0, 16'hFFFF);
  endtask

  task automatic test_thermal_extremes();
    write_reg(CFG_THERMAL_ENERGY, 0);
    send_move(32'sd20000, 0, 16'h0000);
    write_reg(CFG_THERMAL_ENERGY, 64'hFF_FFFF);
    send_move(-32'sd20000, 32'sd9000, 16'hFFFF);
    write_reg(CFG_THERMAL_ENERGY, 1);
    send_move(32'sd4000, 32'sd4000, 16'h0001);
  endtask

  // With sigma zero nothing lies within the cutoff, so every move is taken.
  task automatic test_saturation_and_spacing();
    write_reg(CFG_SIGMA_MEAN, 0);
    send_move(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'h0000);
    send_move(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF);
    write_reg(CFG_GRID_SPACING, 0);
    send_move(-32'sd5, -32'sd5, 16'h1234);
    write_reg(CFG_SIGMA_MEAN, 1);
    send_move(32'sd1, 32'sd1, 16'hABCD);
    write_reg(CFG_GRID_SPACING, RST_GRID_SPACING);
    write_reg(CFG_SIGMA_MEAN, 0);
    send_move(32'sh8000_0001, 32'sh8000_0001, 16'h0000);
    send_move(32'sh8000_0000, 32'sh8000_0000, 16'h5555);
    send_move(32'sh8000_0000, 32'sh8000_0000, 16'hAAAA);
    send_move(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'h0000);
    restore_regs();
  endtask

  task automatic test_wide_geometry();
    write_reg(CFG_GRID_SPACING, 64'hFF_FFFF);
    write_reg(CFG_SIGMA_MEAN, 64'hFF_FFFF);
    send_move(0, 0, 16'h7FFF);
    send_move(32'sd6553600, -32'sd65536, 16'($urandom));
    write_reg(CFG_IDX_W'(3), longint'($urandom));   // unused index is ignored
    restore_regs();
  endtask

  function automatic logic signed [31:0] random_step(longint pos);
    longint span;
    if ($urandom_range(99) < 10) return $signed($urandom);
    if (abs64(pos) > 60 * spacing_reg) return 32'(clamp32(-pos));
    span = spacing_reg / 2 + 1;
    return 32'(clamp32(longint'($urandom_range(0, 32'(2 * span))) - span));
  endfunction

  task automatic test_random_moves();
    int idle_modes[4] = '{0, 86, 0, 14};
    int stall_modes[4] = '{0, 0, 86, 14};
    longint sp;
    for (int ph = 0; ph < 4; ph++) begin
      sp = $urandom_range(1 << 16, 1 << 18);
      write_reg(CFG_GRID_SPACING, sp);
      write_reg(CFG_SIGMA_MEAN, sp * $urandom_range(5, 30) / 100 + 1);
      if ($urandom_range(1)) write_reg(CFG_THERMAL_ENERGY, $urandom_range(1, 24'hFF_FFFF));
      else write_reg(CFG_THERMAL_ENERGY, $urandom_range(500, 100000));
      send_idle_pct = idle_modes[ph];
      stall_pct = stall_modes[ph];
      for (int n = 0; n < 25; n++)
        send_move(random_step(part_x), random_step(part_y), 16'($urandom));
    end
    send_idle_pct = 0;
    stall_pct = 0;
    restore_regs();
  endtask

  // The receiver holds off long enough that the result register and the
  // item in work back up into the input.
  task automatic test_backpressure();
    @(posedge clk);
    hold_off <= 1'b1;
    fork
      begin
        repeat (30000) @(posedge clk);
        hold_off <= 1'b0;
      end
      for (int n = 0; n < 4; n++)
        send_move(random_step(part_x), random_step(part_y), 16'($urandom));
    join
  endtask

  initial begin
    spacing_reg = RST_GRID_SPACING;
    sigma_reg = RST_SIGMA_MEAN;
    kt_reg = RST_THERMAL_ENERGY;
    part_x = 0;
    part_y = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_moves();
    test_thermal_extremes();
    test_saturation_and_spacing();
    test_wide_geometry();
    test_backpressure();
    test_random_moves();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_moves.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
